### src/wrv_pkg.sv
// ----------------------------------------------------------------------------
// wrv_pkg: shared definitions for the weighted running variance unit
// Default sizes, divider widths and the request and response bundles that
// pass between the sequencer and the shared divider.
// ----------------------------------------------------------------------------
package wrv_pkg;

  localparam int VALUE_WIDTH_DEF  = 16;
  localparam int WEIGHT_WIDTH_DEF = 16;
  localparam int COUNT_WIDTH_DEF  = 16;

  localparam int MUL_W      = 32;
  localparam int DIV_REM_W  = 32;
  localparam int DIV_LOW_W  = 64;
  localparam int DIV_STEP_W = 7;

  localparam int OUT_COUNT_W  = 16;
  localparam int OUT_CENTRE_W = 16;
  localparam int OUT_SPREAD_W = 32;

  typedef struct packed {
    logic                  start;
    logic [DIV_REM_W-1:0]  divisor;
    logic [DIV_REM_W-1:0]  rem_init;
    logic [DIV_LOW_W-1:0]  low_init;
    logic [DIV_STEP_W-1:0] steps;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [DIV_LOW_W-1:0] quot;
  } div_rsp_t;

endpackage

### src/wrv_div.sv
// ----------------------------------------------------------------------------
// wrv_div: shared restoring divider
// Produces one quotient bit per cycle. The caller loads the high part of the
// dividend as the starting remainder, which must be below the divisor, and
// the low part left aligned; after the given number of steps the quotient
// sits right aligned in the shift register.
// ----------------------------------------------------------------------------
module wrv_div (
  input  logic               clk,
  input  logic               rst,
  input  wrv_pkg::div_req_t  req,
  output wrv_pkg::div_rsp_t  rsp
);

  logic [wrv_pkg::DIV_REM_W-1:0]  rem;
  logic [wrv_pkg::DIV_REM_W-1:0]  dvsr;
  logic [wrv_pkg::DIV_LOW_W-1:0]  shreg;
  logic [wrv_pkg::DIV_STEP_W-1:0] cnt;
  logic                           busy;
  logic                           done;

  logic [wrv_pkg::DIV_REM_W:0]    trial;
  logic [wrv_pkg::DIV_REM_W:0]    diff;
  logic                           fits;

  always_comb begin
    trial = {rem, shreg[wrv_pkg::DIV_LOW_W-1]};
    diff  = trial - {1'b0, dvsr};
    fits  = (trial >= {1'b0, dvsr});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        rem   <= req.rem_init;
        dvsr  <= req.divisor;
        shreg <= req.low_init;
        cnt   <= req.steps;
        busy  <= 1'b1;
      end else if (busy) begin
        rem   <= fits ? diff[wrv_pkg::DIV_REM_W-1:0] : trial[wrv_pkg::DIV_REM_W-1:0];
        shreg <= {shreg[wrv_pkg::DIV_LOW_W-2:0], fits};
        cnt   <= cnt - 1'b1;
        if (cnt == wrv_pkg::DIV_STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quot = shreg;

  a_start_when_free: assert property (@(posedge clk) disable iff (rst)
    req.start |-> !busy)
    else $error("divider started while busy");

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy) && !busy)
    else $error("divider done without a run");

  a_busy_has_steps: assert property (@(posedge clk) disable iff (rst)
    busy |-> cnt != '0)
    else $error("divider busy with no steps left");

endmodule

### src/weighted_running_variance_unit.sv
// ----------------------------------------------------------------------------
// weighted_running_variance_unit: weighted running variance of a hit cluster
// Each word is one hit. The unit keeps count, weight sum, centre of gravity
// and the sums of the scaled position and its square, and returns count,
// centre and sample variance after every hit.
//
//   port group   dir   tdata (low bit up)                 tuser (low bit up)
//   s_*          in    value, weight                      new_cluster
//   m_*          out   hit_total, centre, spread          spread_valid, saturated
//
// Each hit runs up to four divisions on the shared one-bit-per-cycle divider:
// 32 steps for the relative weight, VALUE_WIDTH for the centre, 64 for the
// squared sum over the count and 32 for the variance. The other states do the
// sequencing and use the shared 32 by 32 multiplier.
// A division whose result is known to be one or to saturate is skipped, and
// the first hit of a cluster skips the variance.
// The next hit is taken once the present one is done; a finished word waits
// in the output register while the next hit is worked on.
// Reset clears the running sums.
// ----------------------------------------------------------------------------
module weighted_running_variance_unit #(
  parameter int VALUE_WIDTH  = wrv_pkg::VALUE_WIDTH_DEF,
  parameter int WEIGHT_WIDTH = wrv_pkg::WEIGHT_WIDTH_DEF,
  parameter int COUNT_WIDTH  = wrv_pkg::COUNT_WIDTH_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // value, weight
  input  logic [((VALUE_WIDTH+WEIGHT_WIDTH+7)/8)*8-1:0] s_tdata,
  // new_cluster
  input  logic [0:0] s_tuser,
  output logic m_tvalid,
  input  logic m_tready,
  // hit_total, centre, spread
  output logic [63:0] m_tdata,
  // spread_valid, saturated
  output logic [1:0] m_tuser
);

  typedef enum logic [4:0] {
    S_IDLE, S_NUM, S_PCHK, S_PDIV, S_XMUL, S_XSQ, S_SQADD, S_CSTART, S_CDIV,
    S_Q0, S_Q1, S_Q2, S_Q3, S_TCHK, S_TDIV, S_SUB, S_SCHK, S_SDIV, S_DONE
  } state_t;

  localparam int MW = wrv_pkg::MUL_W;

  state_t state;

  logic [COUNT_WIDTH-1:0]  count;
  logic [31:0]             wsum;
  logic [VALUE_WIDTH-1:0]  centre_reg;
  logic [63:0]             ssum;
  logic [63:0]             sqsum;

  logic [VALUE_WIDTH-1:0]  v_reg;
  logic [WEIGHT_WIDTH-1:0] w_reg;
  logic [31:0]             denom;
  logic [31:0]             p;
  logic                    xm_big;
  logic [VALUE_WIDTH-1:0]  dmag;
  logic                    dneg;
  logic [63:0]             q1m;
  logic [63:0]             work_hi;
  logic [63:0]             work_lo;
  logic [31:0]             spread;
  logic                    spread_ok;
  logic                    sat;

  logic [MW-1:0]           mul_a;
  logic [MW-1:0]           mul_b;
  logic [2*MW-1:0]         prod;

  wrv_pkg::div_req_t       div_req;
  wrv_pkg::div_rsp_t       div_rsp;

  logic [VALUE_WIDTH-1:0]  vm;
  logic [VALUE_WIDTH:0]    d_full;
  logic [VALUE_WIDTH:0]    d_mag_full;
  logic [32:0]             wsum_add;
  logic                    p_one;
  logic                    p_sat;
  logic [64:0]             sq_add;
  logic [63:0]             sq_val;
  logic [33:0]             mid_sum;
  logic [63:0]             prod_hi_shift;
  logic [COUNT_WIDTH-1:0]  count_new;
  logic [COUNT_WIDTH-1:0]  n_less;
  logic                    t_sat;
  logic                    s_sat;
  logic [WEIGHT_WIDTH-1:0] w_in;

  logic in_take;
  logic out_take;

  assign in_take  = s_tvalid && s_tready;
  assign out_take = m_tvalid && m_tready;
  assign s_tready = (state == S_IDLE);

  always_comb begin
    w_in          = s_tdata[VALUE_WIDTH +: WEIGHT_WIDTH];
    vm            = v_reg[VALUE_WIDTH-1] ? (~v_reg + 1'b1) : v_reg;
    d_full        = {v_reg[VALUE_WIDTH-1], v_reg} - {centre_reg[VALUE_WIDTH-1], centre_reg};
    d_mag_full    = d_full[VALUE_WIDTH] ? (~d_full + 1'b1) : d_full;
    wsum_add      = {1'b0, wsum} + 33'(w_reg);
    p_one         = (count == '0) || (wsum == '0);
    p_sat         = (prod >= {wsum, 16'h0000});
    sq_val        = xm_big ? '1 : prod;
    sq_add        = {1'b0, sqsum} + {1'b0, sq_val};
    mid_sum       = 34'(work_lo[63:32]) + {1'b0, prod[31:0], 1'b0};
    prod_hi_shift = prod >> VALUE_WIDTH;
    count_new     = (count == '1) ? count : count + 1'b1;
    n_less        = count - 1'b1;
    t_sat         = (work_hi >= 64'(count));
    s_sat         = (work_lo[63:32] >= 32'(n_less));
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_NUM: begin
        mul_a = MW'(w_reg);
        mul_b = MW'(count);
      end
      S_XMUL: begin
        mul_a = MW'(vm);
        mul_b = p;
      end
      S_XSQ: begin
        mul_a = prod[47:16];
        mul_b = prod[47:16];
      end
      S_SQADD: begin
        mul_a = MW'(dmag);
        mul_b = MW'(w_reg);
      end
      S_Q0: begin
        mul_a = q1m[31:0];
        mul_b = q1m[31:0];
      end
      S_Q1: begin
        mul_a = q1m[31:0];
        mul_b = q1m[63:32];
      end
      S_Q2: begin
        mul_a = q1m[63:32];
        mul_b = q1m[63:32];
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  always_comb begin
    div_req = '0;
    case (state)
      S_PCHK: begin
        div_req.start    = !p_one && !p_sat;
        div_req.divisor  = wsum;
        div_req.rem_init = prod[47:16];
        div_req.low_init = {prod[15:0], 48'h0};
        div_req.steps    = wrv_pkg::DIV_STEP_W'(32);
      end
      S_CSTART: begin
        div_req.start    = 1'b1;
        div_req.divisor  = denom;
        div_req.rem_init = prod_hi_shift[31:0];
        div_req.low_init = prod << (64 - VALUE_WIDTH);
        div_req.steps    = wrv_pkg::DIV_STEP_W'(VALUE_WIDTH);
      end
      S_TCHK: begin
        div_req.start    = !t_sat;
        div_req.divisor  = 32'(count);
        div_req.rem_init = work_hi[31:0];
        div_req.low_init = work_lo;
        div_req.steps    = wrv_pkg::DIV_STEP_W'(64);
      end
      S_SCHK: begin
        div_req.start    = !s_sat;
        div_req.divisor  = 32'(n_less);
        div_req.rem_init = work_lo[63:32];
        div_req.low_init = {work_lo[31:0], 32'h0};
        div_req.steps    = wrv_pkg::DIV_STEP_W'(32);
      end
      default: begin
        div_req = '0;
      end
    endcase
  end

  wrv_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      m_tvalid   <= 1'b0;
      count      <= '0;
      wsum       <= '0;
      centre_reg <= '0;
      ssum       <= '0;
      sqsum      <= '0;
    end else begin
      if (out_take && state != S_DONE) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_take) begin
            v_reg     <= s_tdata[VALUE_WIDTH-1:0];
            w_reg     <= (w_in == '0) ? WEIGHT_WIDTH'(1) : w_in;
            sat       <= 1'b0;
            spread    <= '0;
            spread_ok <= 1'b0;
            if (s_tuser[0]) begin
              count      <= '0;
              wsum       <= '0;
              centre_reg <= '0;
              ssum       <= '0;
              sqsum      <= '0;
            end
            state <= S_NUM;
          end
        end
        S_NUM: begin
          denom <= wsum_add[32] ? '1 : wsum_add[31:0];
          state <= S_PCHK;
        end
        S_PCHK: begin
          if (p_one) begin
            p     <= 32'h0001_0000;
            state <= S_XMUL;
          end else if (p_sat) begin
            p     <= '1;
            state <= S_XMUL;
          end else begin
            state <= S_PDIV;
          end
        end
        S_PDIV: begin
          if (div_rsp.done) begin
            p     <= div_rsp.quot[31:0];
            state <= S_XMUL;
          end
        end
        S_XMUL: begin
          dneg  <= d_full[VALUE_WIDTH];
          dmag  <= d_mag_full[VALUE_WIDTH-1:0];
          state <= S_XSQ;
        end
        S_XSQ: begin
          xm_big <= |prod[63:48];
          ssum   <= v_reg[VALUE_WIDTH-1] ? ssum - {16'h0, prod[63:16]}
                                         : ssum + {16'h0, prod[63:16]};
          state  <= S_SQADD;
        end
        S_SQADD: begin
          sqsum <= sq_add[64] ? '1 : sq_add[63:0];
          q1m   <= ssum[63] ? (~ssum + 1'b1) : ssum;
          state <= S_CSTART;
        end
        S_CSTART: begin
          state <= S_CDIV;
        end
        S_CDIV: begin
          if (div_rsp.done) begin
            centre_reg <= dneg ? centre_reg - div_rsp.quot[VALUE_WIDTH-1:0]
                               : centre_reg + div_rsp.quot[VALUE_WIDTH-1:0];
            wsum       <= denom;
            count      <= count_new;
            if (count == '1) begin
              sat <= 1'b1;
            end
            if (count_new >= COUNT_WIDTH'(2)) begin
              spread_ok <= 1'b1;
              state     <= S_Q0;
            end else begin
              state <= S_DONE;
            end
          end
        end
        S_Q0: begin
          state <= S_Q1;
        end
        S_Q1: begin
          work_lo <= prod;
          state   <= S_Q2;
        end
        S_Q2: begin
          work_lo <= {mid_sum[31:0], work_lo[31:0]};
          work_hi <= {31'h0, prod[63:32], 1'b0} + 64'(mid_sum[33:32]);
          state   <= S_Q3;
        end
        S_Q3: begin
          work_hi <= work_hi + prod;
          state   <= S_TCHK;
        end
        S_TCHK: begin
          if (t_sat) begin
            work_lo <= '1;
            state   <= S_SUB;
          end else begin
            state <= S_TDIV;
          end
        end
        S_TDIV: begin
          if (div_rsp.done) begin
            work_lo <= div_rsp.quot;
            state   <= S_SUB;
          end
        end
        S_SUB: begin
          work_lo <= (sqsum >= work_lo) ? sqsum - work_lo : '0;
          state   <= S_SCHK;
        end
        S_SCHK: begin
          if (s_sat) begin
            spread <= '1;
            sat    <= 1'b1;
            state  <= S_DONE;
          end else begin
            state <= S_SDIV;
          end
        end
        S_SDIV: begin
          if (div_rsp.done) begin
            spread <= div_rsp.quot[31:0];
            state  <= S_DONE;
          end
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {spread,
                         wrv_pkg::OUT_CENTRE_W'(centre_reg),
                         wrv_pkg::OUT_COUNT_W'(count)};
            m_tuser  <= {sat, spread_ok};
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    in_take |=> state == S_NUM)
    else $error("accepted word did not start the sequence");

  a_div_done_waited: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (state == S_PDIV || state == S_CDIV ||
                      state == S_TDIV || state == S_SDIV))
    else $error("divider result arrived outside a wait state");

  a_invalid_spread_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tdata[63:32] == '0)
    else $error("spread nonzero while marked invalid");

endmodule
